/* rtl/joystick_to_polar_speed_heading_unit_defines.svh */
// assertion macros for the joystick to polar speed and heading unit
`ifndef JOYSTICK_TO_POLAR_SPEED_HEADING_UNIT_DEFINES_SVH
`define JOYSTICK_TO_POLAR_SPEED_HEADING_UNIT_DEFINES_SVH

// checked only while out of reset
`define JTP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define JTP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/jtp_pkg.sv */
// shared types and constants of the joystick to polar speed and heading unit
`timescale 1ns / 1ps
`default_nettype none

package jtp_pkg;

	localparam int ANGLE_BITS      = 16;
	localparam int SPEED_FRAC_BITS = 10;

	localparam int COORD_W   = 8;
	localparam int BUTTON_W  = 2;
	localparam int SPEED_W   = SPEED_FRAC_BITS + 1;
	localparam int POS_SHIFT = 30;
	localparam int PQ_W      = COORD_W + POS_SHIFT + 4;
	localparam int ACC_W     = 32;
	localparam int ATAN_N    = 32;

	// cordic iterations and speed bits, at most one of each per stage
	localparam int NIT_C = (ANGLE_BITS + 4 < ATAN_N) ? ANGLE_BITS + 4 : ATAN_N;
	localparam int NSPD  = SPEED_W;
	localparam int NST   = (NIT_C > NSPD) ? NIT_C : NSPD;

	// speed search: 25 * (2v-1)^2 << LSH <= s * 144 << RSH
	localparam int S_W   = 2 * COORD_W;
	localparam int A_W   = SPEED_FRAC_BITS + 3;
	localparam int SQ_W  = 2 * SPEED_FRAC_BITS + 4;
	localparam int LSH   = (14 > 2 * SPEED_FRAC_BITS) ? 14 - 2 * SPEED_FRAC_BITS : 0;
	localparam int RSH   = (2 * SPEED_FRAC_BITS > 14) ? 2 * SPEED_FRAC_BITS - 14 : 0;
	localparam int LHS_W = SQ_W + 5 + LSH;
	localparam int RHS_W = S_W + 8 + RSH;
	localparam int CMP_W = ((LHS_W > RHS_W) ? LHS_W : RHS_W) + 1;
	localparam int LHS_K = 25;
	localparam int RHS_K = 144;

	localparam logic [ACC_W-1:0] ATAN_TURNS [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic                stick_present;
		logic [COORD_W-1:0]  stick_x;
		logic [COORD_W-1:0]  stick_y;
		logic [BUTTON_W-1:0] button_mask;
	} report_t;

	typedef struct packed {
		logic [SPEED_W-1:0]    speed;
		logic [ANGLE_BITS-1:0] heading;
		logic                  shutdown;
	} result_t;

	typedef struct packed {
		logic                   present;
		logic                   shutdown;
		logic                   yzero;
		logic signed [PQ_W-1:0] p;
		logic signed [PQ_W-1:0] q;
		logic [ACC_W-1:0]       acc;
		logic [S_W-1:0]         s;
		logic [SPEED_W-1:0]     v;
		logic signed [A_W-1:0]  a;
		logic [SQ_W-1:0]        sq;
	} stage_t;

endpackage

`default_nettype wire

/* rtl/jtp_pre.sv */
// input stage: centering, squared length, cordic start vector
`timescale 1ns / 1ps
`default_nettype none

module jtp_pre (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire jtp_pkg::report_t in_rpt,
	input  wire logic             dn_ready,
	output logic                  up_ready,
	output logic                  vld_s1,
	output jtp_pkg::stage_t       data_s1
);

	logic signed [jtp_pkg::COORD_W-1:0] x_c;
	logic signed [jtp_pkg::COORD_W-1:0] y_c;
	logic signed [jtp_pkg::S_W-1:0]     x2;
	logic signed [jtp_pkg::S_W-1:0]     y2;
	logic signed [jtp_pkg::PQ_W-1:0]    p0;
	logic signed [jtp_pkg::PQ_W-1:0]    q0;
	jtp_pkg::stage_t                    nxt;

	assign up_ready = !vld_s1 || dn_ready;

	always_comb begin
		// value - 128 is the raw byte with its top bit flipped
		x_c = signed'({~in_rpt.stick_x[jtp_pkg::COORD_W-1],
			in_rpt.stick_x[jtp_pkg::COORD_W-2:0]});
		y_c = signed'({~in_rpt.stick_y[jtp_pkg::COORD_W-1],
			in_rpt.stick_y[jtp_pkg::COORD_W-2:0]});
		x2 = x_c * x_c;
		y2 = y_c * y_c;
		p0 = jtp_pkg::PQ_W'(y_c) <<< jtp_pkg::POS_SHIFT;
		q0 = jtp_pkg::PQ_W'(x_c) <<< jtp_pkg::POS_SHIFT;

		nxt          = '0;
		nxt.present  = in_rpt.stick_present;
		nxt.shutdown = |in_rpt.button_mask;
		nxt.yzero    = (y_c == '0);
		nxt.s        = jtp_pkg::S_W'(unsigned'(x2)) + jtp_pkg::S_W'(unsigned'(y2));
		if (y_c[jtp_pkg::COORD_W-1]) begin
			nxt.p   = -p0;
			nxt.q   = -q0;
			nxt.acc = jtp_pkg::ACC_W'(1) << (jtp_pkg::ACC_W - 1);
		end else begin
			nxt.p   = p0;
			nxt.q   = q0;
			nxt.acc = '0;
		end
		nxt.v  = '0;
		nxt.a  = '1;
		nxt.sq = jtp_pkg::SQ_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && up_ready) begin
			data_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/jtp_stage.sv */
// one pipeline stage: a cordic vectoring step and one bit of the speed search, each where the index is in range
`timescale 1ns / 1ps
`default_nettype none

module jtp_stage #(
	parameter int IDX = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire jtp_pkg::stage_t in_data,
	input  wire logic            dn_ready,
	output logic                 up_ready,
	output logic                 vld_sn,
	output jtp_pkg::stage_t      data_sn
);

	localparam bit DO_ROT = (IDX < jtp_pkg::NIT_C);
	localparam bit DO_SPD = (IDX < jtp_pkg::NSPD);
	localparam int B      = DO_SPD ? jtp_pkg::NSPD - 1 - IDX : 0;
	localparam int ROT_I  = DO_ROT ? IDX : 0;

	logic signed [jtp_pkg::PQ_W-1:0] ps;
	logic signed [jtp_pkg::PQ_W-1:0] qs;
	logic [jtp_pkg::SQ_W-1:0]        cand;
	logic [jtp_pkg::CMP_W-1:0]       lhs;
	logic [jtp_pkg::CMP_W-1:0]       rhs;
	jtp_pkg::stage_t                 nxt;

	assign up_ready = !vld_sn || dn_ready;

	always_comb begin
		nxt = in_data;
		ps  = in_data.p >>> ROT_I;
		qs  = in_data.q >>> ROT_I;
		if (DO_ROT) begin
			if (!in_data.q[jtp_pkg::PQ_W-1]) begin
				nxt.p   = in_data.p + qs;
				nxt.q   = in_data.q - ps;
				nxt.acc = in_data.acc + jtp_pkg::ATAN_TURNS[ROT_I];
			end else begin
				nxt.p   = in_data.p - qs;
				nxt.q   = in_data.q + ps;
				nxt.acc = in_data.acc - jtp_pkg::ATAN_TURNS[ROT_I];
			end
		end

		// (a + 2^(b+1))^2 from a^2 with shifts and adds
		cand = in_data.sq
			+ (jtp_pkg::SQ_W'(in_data.a) << (B + 2))
			+ (jtp_pkg::SQ_W'(1) << (2 * B + 2));
		lhs = (jtp_pkg::CMP_W'(cand) * jtp_pkg::CMP_W'(jtp_pkg::LHS_K)) << jtp_pkg::LSH;
		rhs = (jtp_pkg::CMP_W'(in_data.s) * jtp_pkg::CMP_W'(jtp_pkg::RHS_K)) << jtp_pkg::RSH;
		if (DO_SPD && (lhs <= rhs)) begin
			nxt.v[B] = 1'b1;
			nxt.a    = in_data.a + (jtp_pkg::A_W'(1) << (B + 1));
			nxt.sq   = cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (up_ready) begin
			vld_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && up_ready) begin
			data_sn <= nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/jtp_out.sv */
// output stage: heading rounding, special cases, output register
`timescale 1ns / 1ps
`default_nettype none

module jtp_out (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire jtp_pkg::stage_t in_data,
	input  wire logic            res_stall,
	output logic                 up_ready,
	output logic                 vld_so,
	output jtp_pkg::result_t     res_so
);

	logic [jtp_pkg::ACC_W-1:0] rnd;
	jtp_pkg::result_t          nxt;

	assign up_ready = !vld_so || !res_stall;

	always_comb begin
		rnd = in_data.acc
			+ (jtp_pkg::ACC_W'(1) << (jtp_pkg::ACC_W - 1 - jtp_pkg::ANGLE_BITS));
		nxt = '0;
		if (in_data.present) begin
			nxt.speed    = in_data.v;
			nxt.shutdown = in_data.shutdown;
			if (!in_data.yzero) begin
				nxt.heading = rnd[jtp_pkg::ACC_W-1 -: jtp_pkg::ANGLE_BITS];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_so <= 1'b0;
		end else if (up_ready) begin
			vld_so <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && up_ready) begin
			res_so <= nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/joystick_to_polar_speed_heading_unit.sv */
// top level of the joystick to polar speed and heading unit
// a report passes the input register, one register per unrolled stage and the output register
// throughput: one report per cycle while result_stall is low, set by the unrolled cordic stages
// each stage advances when its downstream neighbor is empty or moving
// reset clears all valid bits asynchronously; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module joystick_to_polar_speed_heading_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             report_valid,
	output logic                  report_stall,
	input  wire jtp_pkg::report_t report,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output jtp_pkg::result_t      result
);

	logic                 pre_ready;
	logic                 stg_vld  [0:jtp_pkg::NST];
	jtp_pkg::stage_t      stg_data [0:jtp_pkg::NST];
	logic                 stg_rdy  [0:jtp_pkg::NST];

	assign report_stall = !pre_ready;

	jtp_pre u_pre (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (report_valid),
		.in_rpt   (report),
		.dn_ready (stg_rdy[0]),
		.up_ready (pre_ready),
		.vld_s1   (stg_vld[0]),
		.data_s1  (stg_data[0])
	);

	for (genvar k = 0; k < jtp_pkg::NST; k++) begin : g_stage
		jtp_stage #(
			.IDX (k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (stg_vld[k]),
			.in_data  (stg_data[k]),
			.dn_ready (stg_rdy[k+1]),
			.up_ready (stg_rdy[k]),
			.vld_sn   (stg_vld[k+1]),
			.data_sn  (stg_data[k+1])
		);
	end

	jtp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stg_vld[jtp_pkg::NST]),
		.in_data   (stg_data[jtp_pkg::NST]),
		.res_stall (result_stall),
		.up_ready  (stg_rdy[jtp_pkg::NST]),
		.vld_so    (result_valid),
		.res_so    (result)
	);

endmodule

`default_nettype wire

/* rtl/jtp_checker.sv */
// port-level checker for the joystick to polar speed and heading unit
`timescale 1ns / 1ps
`default_nettype none
`include "joystick_to_polar_speed_heading_unit_defines.svh"

module jtp_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             report_stall,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire jtp_pkg::result_t result
);

	// a stalled result stays offered
	`JTP_ASSERT(a_res_hold, clk, arst_n, result_valid && result_stall |=> result_valid, "result dropped while stalled")
	// a stalled result keeps its value
	`JTP_ASSERT(a_res_stable, clk, arst_n, result_valid && result_stall |=> $stable(result), "result changed while stalled")
	// input backs up only when every stage is full and the output is held
	`JTP_ASSERT_ALWAYS(a_stall_full, clk, report_stall |-> result_valid && result_stall, "input stalled with room in the pipe")
	// zero speed means centered stick or no extension, both with zero heading
	`JTP_ASSERT(a_zero_speed, clk, arst_n, result_valid && result.speed == '0 |-> result.heading == '0, "heading set at zero speed")
	// nothing is offered during reset
	`JTP_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !result_valid, "result offered in reset")

endmodule

bind joystick_to_polar_speed_heading_unit jtp_checker u_jtp_checker (.*);

`default_nettype wire
